/* hdl/bpa_pkg.sv */
// package for the buddy page allocator: constants, beat types, helpers
package bpa_pkg;

  localparam int MAX_PAGES  = 16;
  localparam int LEVELS     = 7;
  localparam int LEAF_BYTES = 8192;

  localparam int TOP        = LEVELS - 1;
  localparam int LEAF_SHIFT = $clog2(LEAF_BYTES);
  localparam int PAGE_SHIFT = LEAF_SHIFT + TOP;
  localparam int NODES      = MAX_PAGES << TOP;
  localparam int NODE_W     = $clog2(NODES);
  localparam int PTR_W      = NODE_W + 1;
  localparam int NIL        = NODES;
  localparam int MARKS      = MAX_PAGES << LEVELS;
  localparam int MARK_W     = $clog2(MARKS);
  localparam int LVL_W      = $clog2(LEVELS + 1);
  localparam int KI_W       = $clog2(LEVELS);

  localparam int ADDR_W     = 39;
  localparam int REQ_W      = 24;
  localparam int PC_W       = 5;
  localparam int PC_RESET   = (16 > MAX_PAGES) ? MAX_PAGES : 16;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOMEM = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_PAGE_COUNT  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_A_RD, ST_A_W1, ST_A_W2, ST_A_SP1, ST_A_SP2,
    ST_F_LRD, ST_F_LCK, ST_F_URD, ST_F_UCK, ST_F_MRD, ST_F_MCK,
    ST_F_RW1, ST_F_RW2, ST_F_PU1, ST_F_PU2,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] block_address;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;
  } out_beat_t;

  typedef struct packed {
    logic [PTR_W-1:0] next;
    logic [PTR_W-1:0] prev;
  } link_t;

  typedef struct packed {
    logic              re;
    logic [NODE_W-1:0] raddr;
    logic              we_next;
    logic              we_prev;
    logic [NODE_W-1:0] waddr;
    link_t             wdata;
  } link_req_t;

  typedef struct packed {
    logic used;
    logic split;
  } mark_t;

  typedef struct packed {
    logic              re;
    logic [MARK_W-1:0] raddr;
    logic              we_used;
    logic              we_split;
    logic [MARK_W-1:0] waddr;
    mark_t             wdata;
  } mark_req_t;

  // map index of the block at level k that holds node
  function automatic logic [MARK_W-1:0] mark_at(logic [NODE_W-1:0] node,
                                                logic [LVL_W-1:0] k);
    int page;
    int leaf;
    page = int'(node) >> TOP;
    leaf = int'(node) & ((1 << TOP) - 1);
    return MARK_W'((page << LEVELS) + (1 << (TOP - int'(k))) + (leaf >> int'(k)));
  endfunction

endpackage

/* hdl/bpa_store.sv */
// link memory and mark memory of the buddy allocator, registered reads
module bpa_store (
  input  logic              clk_i,
  input  bpa_pkg::link_req_t link_req_i,
  output bpa_pkg::link_t     link_rdata_o,
  input  bpa_pkg::mark_req_t mark_req_i,
  output bpa_pkg::mark_t     mark_rdata_o
);

  logic [bpa_pkg::PTR_W-1:0] next_mem [bpa_pkg::NODES];
  logic [bpa_pkg::PTR_W-1:0] prev_mem [bpa_pkg::NODES];
  logic                      used_mem [bpa_pkg::MARKS];
  logic                      split_mem[bpa_pkg::MARKS];

  bpa_pkg::link_t link_rd_q;
  bpa_pkg::mark_t mark_rd_q;

  // link memory, lane write enables for next and prev
  always_ff @(posedge clk_i) begin
    if (link_req_i.we_next) begin
      next_mem[link_req_i.waddr] <= link_req_i.wdata.next;
    end
    if (link_req_i.we_prev) begin
      prev_mem[link_req_i.waddr] <= link_req_i.wdata.prev;
    end
    if (link_req_i.re) begin
      link_rd_q.next <= next_mem[link_req_i.raddr];
      link_rd_q.prev <= prev_mem[link_req_i.raddr];
    end
  end

  // mark memory, lane write enables for used and split
  always_ff @(posedge clk_i) begin
    if (mark_req_i.we_used) begin
      used_mem[mark_req_i.waddr] <= mark_req_i.wdata.used;
    end
    if (mark_req_i.we_split) begin
      split_mem[mark_req_i.waddr] <= mark_req_i.wdata.split;
    end
    if (mark_req_i.re) begin
      mark_rd_q.used  <= used_mem[mark_req_i.raddr];
      mark_rd_q.split <= split_mem[mark_req_i.raddr];
    end
  end

  assign link_rdata_o = link_rd_q;
  assign mark_rdata_o = mark_rd_q;

endmodule

/* hdl/buddy_page_allocator_top.sv */
// top level of the buddy page allocator: sequencer, list heads, result register
//
//   channel  | direction | handshake             | beat
//   ---------+-----------+-----------------------+------------------------------
//   cfg      | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//   in       | in        | in_valid_i/in_ready_o | kind, request_bytes, address
//   out      | out       | out_valid_o/out_ready_i | granted_address, status
//
// an allocate reads the head block, unlinks it and marks it used, then splits it
// level by level down to the fitting level; a failed one goes to the result
// a free walks up to the split parent, checks the used mark, merges with each free
// buddy and pushes the block onto its list; a free out of range returns range status
// reset and every page_count write start a clearing pass over the 2048 entries of
// the mark memory, during which no beat is accepted
// the result register lets the next beat in while a result still waits; a
// second finished result holds the sequencer in the done state until it drains

module buddy_page_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [bpa_pkg::ADDR_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bpa_pkg::in_beat_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bpa_pkg::out_beat_t          out_data_o
);

  localparam logic [bpa_pkg::PTR_W-1:0] NIL_P = bpa_pkg::PTR_W'(bpa_pkg::NIL);
  localparam logic [bpa_pkg::ADDR_W-1:0] PAGE_MASK =
    bpa_pkg::ADDR_W'((64'd1 << bpa_pkg::PAGE_SHIFT) - 64'd1);

  bpa_pkg::state_e state_q, state_d;
  logic [bpa_pkg::LVL_W-1:0]  k_q, k_d, fk_q, fk_d;
  logic [bpa_pkg::NODE_W-1:0] node_q, node_d;
  logic [bpa_pkg::PTR_W-1:0]  heads_q [bpa_pkg::LEVELS];
  logic [bpa_pkg::PTR_W-1:0]  heads_d [bpa_pkg::LEVELS];
  logic [bpa_pkg::ADDR_W-1:0] region_q, region_d;
  logic [bpa_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [bpa_pkg::MARK_W-1:0] clr_q, clr_d;
  bpa_pkg::out_beat_t         res_q, res_d, out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  bpa_pkg::link_req_t lreq;
  bpa_pkg::link_t     ldata;
  bpa_pkg::mark_req_t mreq;
  bpa_pkg::mark_t     mdata;

  bpa_store u_store (
    .clk_i        (clk_i),
    .link_req_i   (lreq),
    .link_rdata_o (ldata),
    .mark_req_i   (mreq),
    .mark_rdata_o (mdata)
  );

  // address arithmetic
  logic [bpa_pkg::ADDR_W-1:0] origin, diff, grant_addr;
  logic                       in_range;
  logic [bpa_pkg::NODE_W-1:0] diff_node;

  assign origin     = region_q & ~PAGE_MASK;
  assign diff       = in_data_i.block_address - origin;
  assign in_range   = (diff >> bpa_pkg::PAGE_SHIFT) < bpa_pkg::ADDR_W'(pc_q);
  assign diff_node  = bpa_pkg::NODE_W'(diff >> bpa_pkg::LEAF_SHIFT);
  assign grant_addr = origin + (bpa_pkg::ADDR_W'(node_q) << bpa_pkg::LEAF_SHIFT);

  // smallest fitting level, then first non-empty list at or above it
  logic [bpa_pkg::LVL_W-1:0] fk;
  logic [bpa_pkg::KI_W-1:0]  ksel;
  logic                      kfound;

  always_comb begin
    fk = bpa_pkg::LVL_W'(bpa_pkg::LEVELS);
    for (int f = bpa_pkg::TOP; f >= 0; f--) begin
      if ({40'd0, in_data_i.request_bytes} <= (64'(bpa_pkg::LEAF_BYTES) << f)) begin
        fk = bpa_pkg::LVL_W'(f);
      end
    end
  end

  always_comb begin
    ksel   = '0;
    kfound = 1'b0;
    for (int f = bpa_pkg::TOP; f >= 0; f--) begin
      if (bpa_pkg::LVL_W'(f) >= fk && heads_q[f] != NIL_P) begin
        ksel   = bpa_pkg::KI_W'(f);
        kfound = 1'b1;
      end
    end
  end

  // per-level helpers
  logic [bpa_pkg::NODE_W-1:0] bit_k, bit_km1, buddy, next_half;
  logic [bpa_pkg::LVL_W-1:0]  hidx;
  logic [bpa_pkg::PTR_W-1:0]  head_k;
  logic [bpa_pkg::KI_W-1:0]   kidx;

  assign bit_k     = bpa_pkg::NODE_W'(1) << k_q;
  assign bit_km1   = bpa_pkg::NODE_W'(1) << (k_q - 1'b1);
  assign buddy     = node_q ^ bit_k;
  assign next_half = node_q | bit_km1;
  assign kidx      = k_q[bpa_pkg::KI_W-1:0];
  assign hidx      = (state_q == bpa_pkg::ST_A_SP1 || state_q == bpa_pkg::ST_A_SP2)
                     ? k_q - 1'b1 : k_q;
  assign head_k    = heads_q[hidx[bpa_pkg::KI_W-1:0]];

  logic                     in_fire;
  logic [bpa_pkg::PC_W-1:0] pc_sat;

  assign in_ready_o = (state_q == bpa_pkg::ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign pc_sat     = (int'(cfg_data_i[bpa_pkg::PC_W-1:0]) > bpa_pkg::MAX_PAGES)
                      ? bpa_pkg::PC_W'(bpa_pkg::MAX_PAGES) : cfg_data_i[bpa_pkg::PC_W-1:0];

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    fk_d        = fk_q;
    node_d      = node_q;
    heads_d     = heads_q;
    region_d    = region_q;
    pc_d        = pc_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    lreq        = '0;
    mreq        = '0;

    unique case (state_q) inside
      bpa_pkg::ST_CLEAR: begin
        // wipe marks, relink the top list with the last page first
        mreq.we_used  = 1'b1;
        mreq.we_split = 1'b1;
        mreq.waddr    = clr_q;
        if (int'(clr_q) < int'(pc_q)) begin
          lreq.we_next = 1'b1;
          lreq.we_prev = 1'b1;
          lreq.waddr   = bpa_pkg::NODE_W'(int'(clr_q) << bpa_pkg::TOP);
          lreq.wdata.next = (clr_q == '0) ? NIL_P
                          : bpa_pkg::PTR_W'((int'(clr_q) - 1) << bpa_pkg::TOP);
          lreq.wdata.prev = (int'(clr_q) + 1 == int'(pc_q)) ? NIL_P
                          : bpa_pkg::PTR_W'((int'(clr_q) + 1) << bpa_pkg::TOP);
        end
        if (clr_q == bpa_pkg::MARK_W'(bpa_pkg::MARKS - 1)) begin
          state_d = bpa_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      bpa_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.kind == bpa_pkg::KIND_ALLOC) begin
            if (fk == bpa_pkg::LVL_W'(bpa_pkg::LEVELS) || !kfound) begin
              res_d   = '{granted_address: '0, status: bpa_pkg::STAT_NOMEM};
              state_d = bpa_pkg::ST_DONE;
            end else begin
              node_d  = bpa_pkg::NODE_W'(heads_q[ksel]);
              k_d     = bpa_pkg::LVL_W'(ksel);
              fk_d    = fk;
              state_d = bpa_pkg::ST_A_RD;
            end
          end else begin
            if (!in_range) begin
              res_d   = '{granted_address: '0, status: bpa_pkg::STAT_RANGE};
              state_d = bpa_pkg::ST_DONE;
            end else begin
              node_d  = diff_node;
              k_d     = '0;
              state_d = bpa_pkg::ST_F_LRD;
            end
          end
        end
      end
      bpa_pkg::ST_A_RD: begin
        lreq.re    = 1'b1;
        lreq.raddr = node_q;
        state_d    = bpa_pkg::ST_A_W1;
      end
      bpa_pkg::ST_A_W1, bpa_pkg::ST_F_RW1: begin
        // unlink: predecessor's next or the list head
        if (ldata.prev < NIL_P) begin
          lreq.we_next    = 1'b1;
          lreq.waddr      = bpa_pkg::NODE_W'(ldata.prev);
          lreq.wdata.next = ldata.next;
        end else begin
          heads_d[kidx] = ldata.next;
        end
        if (state_q == bpa_pkg::ST_A_W1) begin
          mreq.we_used      = 1'b1;
          mreq.waddr        = bpa_pkg::mark_at(node_q, k_q);
          mreq.wdata.used   = 1'b1;
          state_d           = bpa_pkg::ST_A_W2;
        end else begin
          state_d = bpa_pkg::ST_F_RW2;
        end
      end
      bpa_pkg::ST_A_W2: begin
        if (ldata.next < NIL_P) begin
          lreq.we_prev    = 1'b1;
          lreq.waddr      = bpa_pkg::NODE_W'(ldata.next);
          lreq.wdata.prev = ldata.prev;
        end
        if (k_q > fk_q) begin
          state_d = bpa_pkg::ST_A_SP1;
        end else begin
          res_d   = '{granted_address: grant_addr, status: bpa_pkg::STAT_OK};
          state_d = bpa_pkg::ST_DONE;
        end
      end
      bpa_pkg::ST_A_SP1: begin
        // mark split, push upper half one level down
        mreq.we_split    = 1'b1;
        mreq.waddr       = bpa_pkg::mark_at(node_q, k_q);
        mreq.wdata.split = 1'b1;
        lreq.we_next     = 1'b1;
        lreq.we_prev     = 1'b1;
        lreq.waddr       = next_half;
        lreq.wdata.next  = head_k;
        lreq.wdata.prev  = NIL_P;
        state_d          = bpa_pkg::ST_A_SP2;
      end
      bpa_pkg::ST_A_SP2: begin
        mreq.we_used    = 1'b1;
        mreq.waddr      = bpa_pkg::mark_at(node_q, k_q - 1'b1);
        mreq.wdata.used = 1'b1;
        if (head_k < NIL_P) begin
          lreq.we_prev    = 1'b1;
          lreq.waddr      = bpa_pkg::NODE_W'(head_k);
          lreq.wdata.prev = {1'b0, next_half};
        end
        heads_d[hidx[bpa_pkg::KI_W-1:0]] = {1'b0, next_half};
        k_d = k_q - 1'b1;
        if (k_q - 1'b1 > fk_q) begin
          state_d = bpa_pkg::ST_A_SP1;
        end else begin
          res_d   = '{granted_address: grant_addr, status: bpa_pkg::STAT_OK};
          state_d = bpa_pkg::ST_DONE;
        end
      end
      bpa_pkg::ST_F_LRD: begin
        // walk up until the parent is split
        if (int'(k_q) < bpa_pkg::TOP) begin
          mreq.re    = 1'b1;
          mreq.raddr = bpa_pkg::mark_at(node_q, k_q + 1'b1);
          state_d    = bpa_pkg::ST_F_LCK;
        end else begin
          state_d = bpa_pkg::ST_F_URD;
        end
      end
      bpa_pkg::ST_F_LCK: begin
        if (!mdata.split) begin
          k_d     = k_q + 1'b1;
          state_d = bpa_pkg::ST_F_LRD;
        end else begin
          state_d = bpa_pkg::ST_F_URD;
        end
      end
      bpa_pkg::ST_F_URD: begin
        node_d     = node_q & ~(bit_k - 1'b1);
        mreq.re    = 1'b1;
        mreq.raddr = bpa_pkg::mark_at(node_q, k_q);
        state_d    = bpa_pkg::ST_F_UCK;
      end
      bpa_pkg::ST_F_UCK: begin
        if (!mdata.used) begin
          // block not in use, nothing to do
          res_d   = '{granted_address: '0, status: bpa_pkg::STAT_OK};
          state_d = bpa_pkg::ST_DONE;
        end else begin
          state_d = bpa_pkg::ST_F_MRD;
        end
      end
      bpa_pkg::ST_F_MRD: begin
        if (int'(k_q) < bpa_pkg::TOP) begin
          mreq.we_used = 1'b1;
          mreq.waddr   = bpa_pkg::mark_at(node_q, k_q);
          mreq.re      = 1'b1;
          mreq.raddr   = bpa_pkg::mark_at(buddy, k_q);
          state_d      = bpa_pkg::ST_F_MCK;
        end else begin
          state_d = bpa_pkg::ST_F_PU1;
        end
      end
      bpa_pkg::ST_F_MCK: begin
        if (mdata.used) begin
          state_d = bpa_pkg::ST_F_PU1;
        end else begin
          lreq.re    = 1'b1;
          lreq.raddr = buddy;
          state_d    = bpa_pkg::ST_F_RW1;
        end
      end
      bpa_pkg::ST_F_RW2: begin
        if (ldata.next < NIL_P) begin
          lreq.we_prev    = 1'b1;
          lreq.waddr      = bpa_pkg::NODE_W'(ldata.next);
          lreq.wdata.prev = ldata.prev;
        end
        // merged parent is neither used nor split
        mreq.we_used  = 1'b1;
        mreq.we_split = 1'b1;
        mreq.waddr    = bpa_pkg::mark_at(node_q & ~bit_k, k_q + 1'b1);
        node_d        = node_q & ~bit_k;
        k_d           = k_q + 1'b1;
        state_d       = bpa_pkg::ST_F_MRD;
      end
      bpa_pkg::ST_F_PU1: begin
        mreq.we_used    = 1'b1;
        mreq.waddr      = bpa_pkg::mark_at(node_q, k_q);
        lreq.we_next    = 1'b1;
        lreq.we_prev    = 1'b1;
        lreq.waddr      = node_q;
        lreq.wdata.next = head_k;
        lreq.wdata.prev = NIL_P;
        state_d         = bpa_pkg::ST_F_PU2;
      end
      bpa_pkg::ST_F_PU2: begin
        if (head_k < NIL_P) begin
          lreq.we_prev    = 1'b1;
          lreq.waddr      = bpa_pkg::NODE_W'(head_k);
          lreq.wdata.prev = {1'b0, node_q};
        end
        heads_d[kidx] = {1'b0, node_q};
        res_d   = '{granted_address: '0, status: bpa_pkg::STAT_OK};
        state_d = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpa_pkg::ST_IDLE;
      end
    endcase

    // the user must write registers only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bpa_pkg::CFG_REGION_BASE: begin
          region_d = cfg_data_i;
        end
        bpa_pkg::CFG_PAGE_COUNT: begin
          pc_d  = pc_sat;
          clr_d = '0;
          for (int l = 0; l < bpa_pkg::LEVELS; l++) begin
            heads_d[l] = NIL_P;
          end
          if (pc_sat != '0) begin
            heads_d[bpa_pkg::TOP] = bpa_pkg::PTR_W'((int'(pc_sat) - 1) << bpa_pkg::TOP);
          end
          state_d = bpa_pkg::ST_CLEAR;
        end
        default: begin
          region_d = region_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::ST_CLEAR;
      k_q         <= '0;
      fk_q        <= '0;
      region_q    <= '0;
      pc_q        <= bpa_pkg::PC_W'(bpa_pkg::PC_RESET);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < bpa_pkg::LEVELS; l++) begin
        heads_q[l] <= NIL_P;
      end
      heads_q[bpa_pkg::TOP] <= bpa_pkg::PTR_W'((bpa_pkg::PC_RESET - 1) << bpa_pkg::TOP);
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      fk_q        <= fk_d;
      region_q    <= region_d;
      pc_q        <= pc_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      heads_q     <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // no same-entry read and write in one cycle on either memory
  a_mark_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mreq.re && (mreq.we_used || mreq.we_split)) |-> mreq.raddr != mreq.waddr)
    else $error("mark memory read and write hit the same entry");

  a_link_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lreq.re && (lreq.we_next || lreq.we_prev)) |-> lreq.raddr != lreq.waddr)
    else $error("link memory read and write hit the same entry");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i) |=> state_q != bpa_pkg::ST_IDLE)
    else $error("accepted beat did not leave idle");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bpa_pkg::ST_IDLE && state_q != bpa_pkg::ST_CLEAR)
      |-> int'(k_q) <= bpa_pkg::TOP)
    else $error("level counter beyond top level");

endmodule
